// ===== rtl/rtcbcd_pkg.sv =====
// rtcbcd_pkg: word types, register bit constants and BCD helpers for the
// RTC BCD date/time codec. No dependencies.

package rtcbcd_pkg;

    localparam logic       CMD_DECODE  = 1'b0;
    localparam logic       CMD_ENCODE  = 1'b1;

    localparam logic [11:0] BASE_YEAR  = 12'd1970;
    localparam logic [11:0] MAX_YEAR   = 12'd2169;
    localparam logic [11:0] CENTURY_YEARS = 12'd100;
    localparam logic [7:0]  CENTURY_OFFSET = 8'd100;

    // bit positions in the hours and month registers
    localparam int MODE12_BIT  = 6;
    localparam int PM_BIT      = 5;
    localparam int CENTURY_BIT = 7;

    typedef struct packed {
        logic        command;
        logic [55:0] register_image;
        logic [5:0]  seconds_in;
        logic [5:0]  minutes_in;
        logic [4:0]  hours_in;
        logic [4:0]  date_in;
        logic [2:0]  weekday_in;
        logic [3:0]  month_in;
        logic [11:0] year_in;
    } item_t;

    typedef struct packed {
        logic [55:0] image_out;
        logic [6:0]  seconds_out;
        logic [6:0]  minutes_out;
        logic [5:0]  hours_out;
        logic [5:0]  date_out;
        logic [2:0]  weekday_out;
        logic [4:0]  month_out;
        logic [11:0] year_out;
    } result_t;

    // tens*10 + units, no digit check; max 165
    function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
        logic [7:0] t8;
        t8 = {4'b0, b[7:4]};
        return (t8 << 3) + (t8 << 1) + {4'b0, b[3:0]};
    endfunction

    // v in 0..99; divide by ten through multiply by 205, shift by 11
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] v);
        logic [17:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {11'b0, v} * 18'd205;
        tens  = prod[14:11];
        units = v - ({tens, 3'b0} + {2'b0, tens, 1'b0});
        return {tens, units[3:0]};
    endfunction

endpackage

// ===== rtl/rtcbcd_decode.sv =====
// rtcbcd_decode: register image to binary calendar fields.
// Depends on rtcbcd_pkg.

module rtcbcd_decode
(
    input  logic [55:0]        image,
    output rtcbcd_pkg::result_t fields
);

    logic [7:0] r0, r1, r2, r3, r4, r5, r6;
    logic [7:0] hr12_raw;
    logic [7:0] hr12_mod;
    logic [7:0] hr24;
    logic [7:0] hour_bin;
    logic [7:0] sec_bin, min_bin, date_bin, mon_bin, yr_bin;
    logic [11:0] year;

    assign r0 = image[7:0];
    assign r1 = image[15:8];
    assign r2 = image[23:16];
    assign r3 = image[31:24];
    assign r4 = image[39:32];
    assign r5 = image[47:40];
    assign r6 = image[55:48];

    always_comb
    begin
        // 12-hour value is at most 25, so mod 12 is two compares
        hr12_raw = rtcbcd_pkg::bcd_to_bin({3'b0, r2[4:0]});
        if (hr12_raw >= 8'd24)
            hr12_mod = hr12_raw - 8'd24;
        else if (hr12_raw >= 8'd12)
            hr12_mod = hr12_raw - 8'd12;
        else
            hr12_mod = hr12_raw;
        hr24 = rtcbcd_pkg::bcd_to_bin({2'b0, r2[5:0]});
        if (r2[rtcbcd_pkg::MODE12_BIT])
            hour_bin = r2[rtcbcd_pkg::PM_BIT] ? hr12_mod + 8'd12 : hr12_mod;
        else
            hour_bin = hr24;
    end

    assign sec_bin  = rtcbcd_pkg::bcd_to_bin({1'b0, r0[6:0]});
    assign min_bin  = rtcbcd_pkg::bcd_to_bin({1'b0, r1[6:0]});
    assign date_bin = rtcbcd_pkg::bcd_to_bin({2'b0, r4[5:0]});
    assign mon_bin  = rtcbcd_pkg::bcd_to_bin({3'b0, r5[4:0]});
    assign yr_bin   = rtcbcd_pkg::bcd_to_bin(r6);

    assign year = rtcbcd_pkg::BASE_YEAR + {4'b0, yr_bin}
                + (r5[rtcbcd_pkg::CENTURY_BIT] ? rtcbcd_pkg::CENTURY_YEARS : 12'd0);

    always_comb
    begin
        fields             = '0;
        fields.seconds_out = sec_bin[6:0];
        fields.minutes_out = min_bin[6:0];
        fields.hours_out   = hour_bin[5:0];
        fields.date_out    = date_bin[5:0];
        fields.weekday_out = r3[2:0];
        fields.month_out   = mon_bin[4:0];
        fields.year_out    = year;
    end

endmodule

// ===== rtl/rtcbcd_encode.sv =====
// rtcbcd_encode: binary calendar fields to a 24-hour register image,
// inputs clamped to range. Depends on rtcbcd_pkg.

module rtcbcd_encode
(
    input  rtcbcd_pkg::item_t   item,
    output rtcbcd_pkg::result_t fields
);

    logic [5:0]  sec, mins;
    logic [4:0]  hr, dt;
    logic [2:0]  wd;
    logic [3:0]  mo;
    logic [11:0] yr;
    logic [7:0]  off;
    logic [7:0]  off_yy;
    logic        century;
    logic [7:0]  mreg;

    always_comb
    begin
        sec  = (item.seconds_in > 6'd59) ? 6'd59 : item.seconds_in;
        mins = (item.minutes_in > 6'd59) ? 6'd59 : item.minutes_in;
        hr   = (item.hours_in > 5'd23) ? 5'd23 : item.hours_in;
        dt   = (item.date_in == 5'd0) ? 5'd1 : item.date_in;
        wd   = (item.weekday_in == 3'd0) ? 3'd1 : item.weekday_in;
        if (item.month_in == 4'd0)
            mo = 4'd1;
        else if (item.month_in > 4'd12)
            mo = 4'd12;
        else
            mo = item.month_in;
        if (item.year_in < rtcbcd_pkg::BASE_YEAR)
            yr = rtcbcd_pkg::BASE_YEAR;
        else if (item.year_in > rtcbcd_pkg::MAX_YEAR)
            yr = rtcbcd_pkg::MAX_YEAR;
        else
            yr = item.year_in;
    end

    // offset from base year is 0..199
    assign off     = 8'(yr - rtcbcd_pkg::BASE_YEAR);
    assign century = (off >= rtcbcd_pkg::CENTURY_OFFSET);
    assign off_yy  = century ? off - rtcbcd_pkg::CENTURY_OFFSET : off;
    assign mreg    = rtcbcd_pkg::bin_to_bcd({3'b0, mo})
                   | {century, 7'b0};

    always_comb
    begin
        fields           = '0;
        fields.image_out = {rtcbcd_pkg::bin_to_bcd(off_yy[6:0]),
                            mreg,
                            rtcbcd_pkg::bin_to_bcd({2'b0, dt}),
                            rtcbcd_pkg::bin_to_bcd({4'b0, wd}),
                            rtcbcd_pkg::bin_to_bcd({2'b0, hr}),
                            rtcbcd_pkg::bin_to_bcd({1'b0, mins}),
                            rtcbcd_pkg::bin_to_bcd({1'b0, sec})};
    end

endmodule

// ===== rtl/rtc_bcd_datetime_codec_core.sv =====
// rtc_bcd_datetime_codec_core: top level of the RTC BCD date/time codec.
// Depends on rtcbcd_pkg, rtcbcd_decode and rtcbcd_encode.
//
// Usage:
//   Command channel: drive item and raise start; the word is taken at any
//   rising edge with start high and busy low. busy is always low, so a new
//   word may be issued every cycle.
//   item.command selects decode (image to fields) or encode (fields to a
//   24-hour image). Fields that the chosen operation does not produce are 0.
//   Result channel: done pulses for exactly one cycle with result valid in
//   that same cycle. The receiver has no way to stall; it must capture the
//   word on that edge.
//   The word passes the input register, then the result register, from the
//   accepting edge to done. Throughput: one word per cycle, set by the single
//   registered conversion stage.
//   Reset (rst_n low, asynchronous) drops any word in flight; no result is
//   produced for it. There is no other state.

module rtc_bcd_datetime_codec_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rtcbcd_pkg::item_t   item,
    output logic                done,
    output rtcbcd_pkg::result_t result
);

    // input stage
    logic                in_valid_reg;
    rtcbcd_pkg::item_t   item_reg;

    // result stage
    logic                done_reg;
    rtcbcd_pkg::result_t result_reg;
    rtcbcd_pkg::result_t result_next;

    rtcbcd_pkg::result_t dec_fields;
    rtcbcd_pkg::result_t enc_fields;

    // conversion is a single pass, never stalls
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start;
            done_reg     <= in_valid_reg;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
            item_reg <= item;
        if (in_valid_reg)
            result_reg <= result_next;
    end

    rtcbcd_decode u_decode
    (
        .image  (item_reg.register_image),
        .fields (dec_fields)
    );

    rtcbcd_encode u_encode
    (
        .item   (item_reg),
        .fields (enc_fields)
    );

    // each unit zeroes the fields it does not own
    assign result_next = (item_reg.command == rtcbcd_pkg::CMD_ENCODE) ? enc_fields
                                                                       : dec_fields;

    assign done   = done_reg;
    assign result = result_reg;

endmodule
